/* rtl/core/llm_pkg.sv */
// Shared types, codes and arithmetic helpers for the loopback latency meter.
`default_nettype none

package llm_pkg;

  localparam int SMP_W = 24;
  localparam int SUM_W = SMP_W + 2;
  localparam int LAT_W = 20;
  localparam int LEN_W = 20;
  localparam int THR_W = 23;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 23;

  localparam logic signed [SUM_W-1:0] FULL_SCALE = SUM_W'(8388608);
  localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(8388607);
  localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(8388608);

  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_READ    = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PULSE_LEN = 3'd0,
    CFG_IDLE_LEN  = 3'd1,
    CFG_THRESHOLD = 3'd2,
    CFG_INVERT    = 3'd3,
    CFG_ECHO      = 3'd4
  } cfg_idx_t;

  // Request from the result stage to the phase sequencer.
  typedef struct packed {
    logic go;
    logic frame;
    logic restart;
  } seq_req_t;

  // Phase status as it stands after the current item.
  typedef struct packed {
    logic clear;
    logic pulse_on;
    logic done;
  } seq_stat_t;

  // Request from the result stage to the channel measurement store.
  typedef struct packed {
    logic go;
    logic sample;
    logic above;
    logic clear;
  } meas_req_t;

  function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [SUM_W-1:0] v);
    logic signed [SMP_W-1:0] r;
    if (v > OUT_MAX) begin
      r = OUT_MAX[SMP_W-1:0];
    end else if (v < OUT_MIN) begin
      r = OUT_MIN[SMP_W-1:0];
    end else begin
      r = v[SMP_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/llm_if.sv */
// Item channel interfaces for the loopback latency meter.
`default_nettype none

interface llm_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic [2:0]               channel;
  logic signed [23:0]       sample;

  modport source (output valid, kind, channel, sample, input ready);
  modport sink (input valid, kind, channel, sample, output ready);
endinterface

interface llm_out_if;
  logic                     valid;
  logic                     ready;
  logic signed [23:0]       out_sample;
  logic [19:0]              latency;
  logic                     detected;
  logic                     done_res;
  logic                     pulse_on;

  modport source (output valid, out_sample, latency, detected, done_res, pulse_on,
                  input ready);
  modport sink (input valid, out_sample, latency, detected, done_res, pulse_on,
                output ready);
endinterface

`default_nettype wire

/* rtl/core/llm_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module llm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/llm_seq.sv */
// Four-phase test sequencer: reset, pulse, quiet and done, stepped once per frame.
`default_nettype none

module llm_seq (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire llm_pkg::seq_req_t           req,
  input  wire logic [llm_pkg::LEN_W-1:0]   pulse_len,
  input  wire logic [llm_pkg::LEN_W-1:0]   idle_len,
  output llm_pkg::seq_stat_t               stat
);

  typedef enum logic [1:0] {
    PH_RESET = 2'd0,
    PH_PULSE = 2'd1,
    PH_QUIET = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  phase_t                    ph_r, ph_nxt;
  logic [llm_pkg::LEN_W-1:0] cnt_r, cnt_nxt;
  logic [llm_pkg::LEN_W-1:0] cnt_inc;
  logic                      clear;

  assign cnt_inc = cnt_r + 1'b1;

  always_comb begin
    ph_nxt  = ph_r;
    cnt_nxt = cnt_r;
    clear   = 1'b0;
    if (req.restart) begin
      ph_nxt = PH_RESET;
    end else if (req.frame) begin
      unique case (ph_r)
        PH_RESET: begin
          clear   = 1'b1;
          cnt_nxt = '0;
          ph_nxt  = PH_PULSE;
        end
        PH_PULSE: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= pulse_len) begin
            cnt_nxt = '0;
            ph_nxt  = PH_QUIET;
          end
        end
        PH_QUIET: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= idle_len) begin
            cnt_nxt = '0;
            ph_nxt  = PH_DONE;
          end
        end
        PH_DONE: begin
          ph_nxt = PH_DONE;
        end
        default: begin
          ph_nxt = PH_DONE;
        end
      endcase
    end
  end

  assign stat.clear    = clear;
  assign stat.pulse_on = (ph_nxt == PH_PULSE);
  assign stat.done     = (ph_nxt == PH_DONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_RESET;
      cnt_r <= '0;
    end else if (req.go) begin
      ph_r  <= ph_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_DONE && !(req.go && req.restart)) |=> ph_r == PH_DONE)
    else $error("Sequencer left the done phase without a restart.");

  a_reset_to_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_RESET && req.go && req.frame && !req.restart)
      |=> (ph_r == PH_PULSE && cnt_r == '0))
    else $error("Frame start in the reset phase did not enter a fresh pulse phase.");

endmodule

`default_nettype wire

/* rtl/core/llm_meas.sv */
// Per-channel measurement store: RAM read-modify-write with valid bits and forwarding.
`default_nettype none

module llm_meas #(
  parameter int CHANNELS   = 8,
  parameter int COUNT_BITS = 20
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire logic                                         rd_en,
  input  wire logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] rd_addr,
  input  wire logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] addr,
  input  wire llm_pkg::meas_req_t                           req,
  output logic      [COUNT_BITS-1:0]                        lat,
  output logic                                              cap
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int VN = 1 << AW;
  localparam int EW = 2 * COUNT_BITS + 1;

  logic [EW-1:0]         rdata;
  logic [EW-1:0]         old_ent, ent, wdata;
  logic                  we;
  logic [VN-1:0]         vld_r, vld_nxt;
  logic                  fwd_v_r;
  logic [AW-1:0]         fwd_addr_r;
  logic [EW-1:0]         fwd_data_r;
  logic [COUNT_BITS-1:0] cnt, cnt_new, lat_new;
  logic                  cap_new;

  llm_ram #(
    .WIDTH (EW),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // The entry written in the cycle of the read is not yet in the read data.
  assign old_ent = (fwd_v_r && fwd_addr_r == addr) ? fwd_data_r : rdata;
  assign ent     = (req.clear || !vld_r[addr]) ? '0 : old_ent;

  assign cnt = ent[EW-1 -: COUNT_BITS];
  assign lat = ent[COUNT_BITS:1];
  assign cap = ent[0];

  always_comb begin
    cnt_new = cnt;
    lat_new = lat;
    cap_new = cap;
    if (!cap) begin
      if (req.above) begin
        lat_new = cnt;
        cap_new = 1'b1;
      end else if (cnt != '1) begin
        cnt_new = cnt + 1'b1;
      end
    end
  end

  assign wdata = {cnt_new, lat_new, cap_new};
  assign we    = req.go && req.sample;

  always_comb begin
    vld_nxt = vld_r;
    if (req.go && req.clear) begin
      vld_nxt = '0;
    end
    if (we) begin
      vld_nxt[addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      fwd_v_r <= 1'b0;
    end else begin
      vld_r   <= vld_nxt;
      fwd_v_r <= we ? 1'b1 : fwd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      fwd_addr_r <= addr;
      fwd_data_r <= wdata;
    end
  end

  a_written_valid: assert property (@(posedge clk) disable iff (!rst_n)
    we |=> vld_r[$past(addr)])
    else $error("Written channel entry is not marked valid.");

endmodule

`default_nettype wire

/* rtl/core/loopback_latency_meter.sv */
// Top level of the round-trip audio latency meter.
//
//   Channel  Direction  Handshake      Payload
//   in_ch    in         valid/ready    kind, channel, sample
//   out_ch   out        valid/ready    out_sample, latency, detected, done_res, pulse_on
//   cfg_*    in         cfg_we only    cfg_idx, cfg_data
//
// One item enters per cycle while the output is not stalled. The measurement RAM is
// read at the accepting edge, into the update stage; when that stage moves on, the
// entry is updated, the phase sequencer steps and the output register loads the result.
// Reset is synchronous; all channel entries read as cleared with no sweep.
// A stalled output holds the item in the update stage and blocks new input.
`default_nettype none

module loopback_latency_meter #(
  parameter int CHANNELS   = 8,
  parameter int COUNT_BITS = 20
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  llm_in_if.sink                                   in_ch,
  llm_out_if.source                                out_ch,
  input  wire logic                                cfg_we,
  input  wire logic [llm_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [llm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [llm_pkg::LEN_W-1:0] pulse_len_r, idle_len_r;
  logic [llm_pkg::THR_W-1:0] thr_r;
  logic                      inv_r, echo_r;

  logic                              s1_v_r;
  logic [1:0]                        s1_kind_r;
  logic [2:0]                        s1_ch_r;
  logic signed [llm_pkg::SMP_W-1:0]  s1_smp_r;

  logic                              out_v_r;
  logic signed [llm_pkg::SMP_W-1:0]  out_smp_r, out_smp_nxt;
  logic [llm_pkg::LAT_W-1:0]         out_lat_r, out_lat_nxt;
  logic                              out_det_r, out_det_nxt;
  logic                              out_done_r, out_pulse_r;

  logic go, acc, ch_ok, is_smp, is_read, above, echo_on;
  logic signed [llm_pkg::SUM_W-1:0] total, total_inv;
  llm_pkg::seq_req_t  seq_req;
  llm_pkg::seq_stat_t seq_stat;
  llm_pkg::meas_req_t meas_req;
  logic [COUNT_BITS-1:0] m_lat;
  logic                  m_cap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_len_r <= llm_pkg::LEN_W'(10);
      idle_len_r  <= llm_pkg::LEN_W'(14400);
      thr_r       <= llm_pkg::THR_W'(4194304);
      inv_r       <= 1'b0;
      echo_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        llm_pkg::CFG_PULSE_LEN: pulse_len_r <= cfg_data[llm_pkg::LEN_W-1:0];
        llm_pkg::CFG_IDLE_LEN:  idle_len_r  <= cfg_data[llm_pkg::LEN_W-1:0];
        llm_pkg::CFG_THRESHOLD: thr_r       <= cfg_data[llm_pkg::THR_W-1:0];
        llm_pkg::CFG_INVERT:    inv_r       <= cfg_data[0];
        llm_pkg::CFG_ECHO:      echo_r      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign go           = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !s1_v_r || go;
  assign acc          = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_kind_r <= in_ch.kind;
      s1_ch_r   <= in_ch.channel;
      s1_smp_r  <= in_ch.sample;
    end
  end

  assign ch_ok   = int'(s1_ch_r) < CHANNELS;
  assign is_smp  = (s1_kind_r == llm_pkg::KIND_SAMPLE);
  assign is_read = (s1_kind_r == llm_pkg::KIND_READ);
  assign above   = s1_smp_r > $signed({1'b0, thr_r});

  assign seq_req.go      = go;
  assign seq_req.frame   = is_smp && (s1_ch_r == '0);
  assign seq_req.restart = (s1_kind_r == llm_pkg::KIND_RESTART);

  llm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (seq_req),
    .pulse_len (pulse_len_r),
    .idle_len  (idle_len_r),
    .stat      (seq_stat)
  );

  assign meas_req.go     = go;
  assign meas_req.sample = is_smp && ch_ok;
  assign meas_req.above  = above;
  assign meas_req.clear  = seq_stat.clear;

  llm_meas #(
    .CHANNELS   (CHANNELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_meas (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (acc),
    .rd_addr (AW'(in_ch.channel)),
    .addr    (AW'(s1_ch_r)),
    .req     (meas_req),
    .lat     (m_lat),
    .cap     (m_cap)
  );

  // Inputs above threshold are positive, so the arithmetic shift truncates toward zero.
  assign echo_on   = ch_ok && above && echo_r;
  assign total     = (seq_stat.pulse_on ? llm_pkg::FULL_SCALE : '0)
                   - (echo_on ? llm_pkg::SUM_W'(s1_smp_r >>> 1) : '0);
  assign total_inv = inv_r ? -total : total;

  assign out_smp_nxt = is_smp ? llm_pkg::sat_smp(total_inv) : '0;
  assign out_lat_nxt = (is_read && ch_ok) ? llm_pkg::LAT_W'(m_lat) : '0;
  assign out_det_nxt = is_read && ch_ok && m_cap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (go) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_smp_r   <= out_smp_nxt;
      out_lat_r   <= out_lat_nxt;
      out_det_r   <= out_det_nxt;
      out_done_r  <= seq_stat.done;
      out_pulse_r <= seq_stat.pulse_on;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.out_sample = out_smp_r;
  assign out_ch.latency    = out_lat_r;
  assign out_ch.detected   = out_det_r;
  assign out_ch.done_res   = out_done_r;
  assign out_ch.pulse_on   = out_pulse_r;

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !go) |=> (s1_v_r && $stable(s1_kind_r) && $stable(s1_ch_r)
                         && $stable(s1_smp_r)))
    else $error("Item in the update stage changed while stalled.");

  a_status_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(out_done_r && out_pulse_r))
    else $error("Result reports pulse and done at once.");

endmodule

`default_nettype wire
